// ----- sv/cqfa_pkg.sv -----
// shared types and constants for the complex quadratic field alu
`default_nettype none
package cqfa_pkg;

  localparam int NUM_COEFF  = 4;
  localparam int PART_WIDTH = 64;
  localparam int MODE_WIDTH = 3;

  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_MUL       = 3'd0,
    MODE_ADD       = 3'd1,
    MODE_SUB       = 3'd2,
    MODE_ADD_CSWAP = 3'd3,
    MODE_SUB_CSWAP = 3'd4
  } cqfa_mode_e;

  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } cqfa_lane_ctrl_t;

endpackage
`default_nettype wire

// ----- sv/cqfa_if.sv -----
// valid/ready channel interfaces for operands and results
`default_nettype none
interface cqfa_in_if;
  import cqfa_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [MODE_WIDTH-1:0]         mode;
  logic [PART_WIDTH-1:0]         a_re;
  logic [PART_WIDTH-1:0]         a_im;
  logic [PART_WIDTH-1:0]         b_re;
  logic [PART_WIDTH-1:0]         b_im;

  modport source (output valid, mode, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, mode, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cqfa_out_if;
  import cqfa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [PART_WIDTH-1:0] c_re;
  logic [PART_WIDTH-1:0] c_im;
  logic                  overflow;

  modport source (output valid, c_re, c_im, overflow, input ready);
  modport sink   (input valid, c_re, c_im, overflow, output ready);
endinterface
`default_nettype wire

// ----- sv/complex_quadratic_field_alu.sv -----
// top level of the complex alu over Q(sqrt3, sqrt5)
`default_nettype none
// Complex ALU whose real and imaginary parts are elements of Q(sqrt3, sqrt5),
// each held as four packed signed COEFF_WIDTH-bit coefficients on the basis
// 1, sqrt3, sqrt5, sqrt15. Modes are multiply, add, subtract and the two
// conjugate-swap forms; every result coefficient saturates and any clip sets
// overflow. Unused mode codes give an all-zero result. The block accepts one
// operation per clock while the sink keeps up, passing it through the partial
// product registers of the four multiplier lanes, the lane reduction registers
// and the merge and saturation output register. A stalled output holds the
// pipeline in place; each stage refills as soon as the one after it moves, so
// throughput stays one per cycle while the sink keeps up.
module complex_quadratic_field_alu #(
  parameter int COEFF_WIDTH = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  cqfa_in_if.sink    in_i,
  cqfa_out_if.source out_o
);
  import cqfa_pkg::*;

  localparam int CW = COEFF_WIDTH;
  localparam int SW = 2 * CW + 5;

  // unpacked operand coefficients straight off the input channel
  logic signed [CW-1:0] ar [NUM_COEFF];
  logic signed [CW-1:0] ai [NUM_COEFF];
  logic signed [CW-1:0] br [NUM_COEFF];
  logic signed [CW-1:0] bi [NUM_COEFF];

  // operands and mode delayed alongside the lanes for the add paths
  logic signed [CW-1:0] ar1_q [NUM_COEFF];
  logic signed [CW-1:0] ai1_q [NUM_COEFF];
  logic signed [CW-1:0] br1_q [NUM_COEFF];
  logic signed [CW-1:0] bi1_q [NUM_COEFF];
  logic signed [CW-1:0] ar2_q [NUM_COEFF];
  logic signed [CW-1:0] ai2_q [NUM_COEFF];
  logic signed [CW-1:0] br2_q [NUM_COEFF];
  logic signed [CW-1:0] bi2_q [NUM_COEFF];
  logic [MODE_WIDTH-1:0] mode1_q, mode2_q;

  // stage occupancy
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  cqfa_lane_ctrl_t lane_ctrl;

  logic signed [SW-1:0] t_rr [NUM_COEFF];
  logic signed [SW-1:0] t_ii [NUM_COEFF];
  logic signed [SW-1:0] t_ri [NUM_COEFF];
  logic signed [SW-1:0] t_ir [NUM_COEFF];

  logic [NUM_COEFF*CW-1:0] c_re, c_im;
  logic                    ovf;

  // bits above the packed coefficients are ignored
  always_comb begin
    for (int i = 0; i < NUM_COEFF; i++) begin
      ar[i] = in_i.a_re[i*CW +: CW];
      ai[i] = in_i.a_im[i*CW +: CW];
      br[i] = in_i.b_re[i*CW +: CW];
      bi[i] = in_i.b_im[i*CW +: CW];
    end
  end

  // a stage moves when it is empty or the next one moves
  assign adv3 = !v3_q || out_o.ready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign in_i.ready = adv1;

  assign lane_ctrl.mul_en = adv1;
  assign lane_ctrl.sum_en = adv2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_i.valid;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      mode1_q <= in_i.mode;
      ar1_q   <= ar;
      ai1_q   <= ai;
      br1_q   <= br;
      bi1_q   <= bi;
    end
    if (adv2) begin
      mode2_q <= mode1_q;
      ar2_q   <= ar1_q;
      ai2_q   <= ai1_q;
      br2_q   <= br1_q;
      bi2_q   <= bi1_q;
    end
  end

  // four lanes, one quad product each
  cqfa_lane #(.CW(CW)) u_lane_rr (
    .clk_i (clk_i), .ctrl_i (lane_ctrl), .p_i (ar), .q_i (br), .r_o (t_rr)
  );
  cqfa_lane #(.CW(CW)) u_lane_ii (
    .clk_i (clk_i), .ctrl_i (lane_ctrl), .p_i (ai), .q_i (bi), .r_o (t_ii)
  );
  cqfa_lane #(.CW(CW)) u_lane_ri (
    .clk_i (clk_i), .ctrl_i (lane_ctrl), .p_i (ar), .q_i (bi), .r_o (t_ri)
  );
  cqfa_lane #(.CW(CW)) u_lane_ir (
    .clk_i (clk_i), .ctrl_i (lane_ctrl), .p_i (ai), .q_i (br), .r_o (t_ir)
  );

  // combine lanes or operands, clip and register the result
  cqfa_merge #(.CW(CW)) u_merge (
    .clk_i      (clk_i),
    .en_i       (adv3),
    .mode_i     (mode2_q),
    .ar_i       (ar2_q),
    .ai_i       (ai2_q),
    .br_i       (br2_q),
    .bi_i       (bi2_q),
    .t_rr_i     (t_rr),
    .t_ii_i     (t_ii),
    .t_ri_i     (t_ri),
    .t_ir_i     (t_ir),
    .c_re_o     (c_re),
    .c_im_o     (c_im),
    .overflow_o (ovf)
  );

  // output bits above the packed coefficients read as zero
  assign out_o.valid    = v3_q;
  assign out_o.c_re     = PART_WIDTH'(c_re);
  assign out_o.c_im     = PART_WIDTH'(c_im);
  assign out_o.overflow = ovf;

endmodule
`default_nettype wire

// ----- sv/cqfa_lane.sv -----
// one quad product lane: registered partial products, then registered reduction
`default_nettype none
module cqfa_lane #(
  parameter int CW = 16
) (
  input  wire                             clk_i,
  input  wire cqfa_pkg::cqfa_lane_ctrl_t  ctrl_i,
  input  wire logic signed [CW-1:0]       p_i [cqfa_pkg::NUM_COEFF],
  input  wire logic signed [CW-1:0]       q_i [cqfa_pkg::NUM_COEFF],
  output logic signed [2*CW+4:0]          r_o [cqfa_pkg::NUM_COEFF]
);
  import cqfa_pkg::*;

  localparam int PW = 2 * CW;
  localparam int SW = PW + 5;

  logic signed [PW-1:0] prod_q [NUM_COEFF][NUM_COEFF];
  logic signed [PW-1:0] prod_d [NUM_COEFF][NUM_COEFF];
  logic signed [SW-1:0] e      [NUM_COEFF][NUM_COEFF];
  logic signed [SW-1:0] r_d    [NUM_COEFF];
  logic signed [SW-1:0] r_q    [NUM_COEFF];

  always_comb begin
    for (int i = 0; i < NUM_COEFF; i++) begin
      for (int j = 0; j < NUM_COEFF; j++) begin
        prod_d[i][j] = p_i[i] * q_i[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_COEFF; i++) begin
      for (int j = 0; j < NUM_COEFF; j++) begin
        e[i][j] = {{(SW-PW){prod_q[i][j][PW-1]}}, prod_q[i][j]};
      end
    end
    // times 3, 5 and 15 as shift-add
    r_d[0] = e[0][0] + ((e[1][1] <<< 1) + e[1][1]) + ((e[2][2] <<< 2) + e[2][2])
           + ((e[3][3] <<< 4) - e[3][3]);
    r_d[1] = e[0][1] + e[1][0] + (((e[2][3] + e[3][2]) <<< 2) + (e[2][3] + e[3][2]));
    r_d[2] = e[0][2] + e[2][0] + (((e[1][3] + e[3][1]) <<< 1) + (e[1][3] + e[3][1]));
    r_d[3] = e[0][3] + e[3][0] + e[1][2] + e[2][1];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      r_q <= r_d;
    end
  end

  assign r_o = r_q;

endmodule
`default_nettype wire

// ----- sv/cqfa_merge.sv -----
// merge of lane results and add paths, saturation and output register
`default_nettype none
module cqfa_merge #(
  parameter int CW = 16
) (
  input  wire                                  clk_i,
  input  wire                                  en_i,
  input  wire [cqfa_pkg::MODE_WIDTH-1:0]       mode_i,
  input  wire logic signed [CW-1:0]            ar_i   [cqfa_pkg::NUM_COEFF],
  input  wire logic signed [CW-1:0]            ai_i   [cqfa_pkg::NUM_COEFF],
  input  wire logic signed [CW-1:0]            br_i   [cqfa_pkg::NUM_COEFF],
  input  wire logic signed [CW-1:0]            bi_i   [cqfa_pkg::NUM_COEFF],
  input  wire logic signed [2*CW+4:0]          t_rr_i [cqfa_pkg::NUM_COEFF],
  input  wire logic signed [2*CW+4:0]          t_ii_i [cqfa_pkg::NUM_COEFF],
  input  wire logic signed [2*CW+4:0]          t_ri_i [cqfa_pkg::NUM_COEFF],
  input  wire logic signed [2*CW+4:0]          t_ir_i [cqfa_pkg::NUM_COEFF],
  output logic [cqfa_pkg::NUM_COEFF*CW-1:0]    c_re_o,
  output logic [cqfa_pkg::NUM_COEFF*CW-1:0]    c_im_o,
  output logic                                 overflow_o
);
  import cqfa_pkg::*;

  localparam int SW = 2 * CW + 5;
  localparam int MW = SW + 1;
  localparam logic signed [MW-1:0] SAT_MAX = MW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [MW-1:0] SAT_MIN = ~SAT_MAX;

  logic signed [MW-1:0]      re_w [NUM_COEFF];
  logic signed [MW-1:0]      im_w [NUM_COEFF];
  logic signed [MW-1:0]      ar_x, ai_x, br_x, bi_x;
  logic [NUM_COEFF*CW-1:0]   c_re_d, c_im_d, c_re_q, c_im_q;
  logic                      ovf_d, ovf_q;
  logic                      valid_mode;

  always_comb begin
    valid_mode = 1'b1;
    for (int i = 0; i < NUM_COEFF; i++) begin
      ar_x = {{(MW-CW){ar_i[i][CW-1]}}, ar_i[i]};
      ai_x = {{(MW-CW){ai_i[i][CW-1]}}, ai_i[i]};
      br_x = {{(MW-CW){br_i[i][CW-1]}}, br_i[i]};
      bi_x = {{(MW-CW){bi_i[i][CW-1]}}, bi_i[i]};
      case (mode_i)
        MODE_MUL: begin
          re_w[i] = {t_rr_i[i][SW-1], t_rr_i[i]} - {t_ii_i[i][SW-1], t_ii_i[i]};
          im_w[i] = {t_ri_i[i][SW-1], t_ri_i[i]} + {t_ir_i[i][SW-1], t_ir_i[i]};
        end
        MODE_ADD: begin
          re_w[i] = ar_x + br_x;
          im_w[i] = ai_x + bi_x;
        end
        MODE_SUB: begin
          re_w[i] = ar_x - br_x;
          im_w[i] = ai_x - bi_x;
        end
        MODE_ADD_CSWAP: begin
          re_w[i] = ar_x + bi_x;
          im_w[i] = ai_x - br_x;
        end
        MODE_SUB_CSWAP: begin
          re_w[i] = ar_x - bi_x;
          im_w[i] = ai_x + br_x;
        end
        default: begin
          re_w[i]    = '0;
          im_w[i]    = '0;
          valid_mode = 1'b0;
        end
      endcase
    end
  end

  // clip each coefficient to the signed range
  always_comb begin
    ovf_d = 1'b0;
    for (int i = 0; i < NUM_COEFF; i++) begin
      if (re_w[i] > SAT_MAX) begin
        c_re_d[i*CW +: CW] = SAT_MAX[CW-1:0];
        ovf_d = 1'b1;
      end else if (re_w[i] < SAT_MIN) begin
        c_re_d[i*CW +: CW] = SAT_MIN[CW-1:0];
        ovf_d = 1'b1;
      end else begin
        c_re_d[i*CW +: CW] = re_w[i][CW-1:0];
      end
      if (im_w[i] > SAT_MAX) begin
        c_im_d[i*CW +: CW] = SAT_MAX[CW-1:0];
        ovf_d = 1'b1;
      end else if (im_w[i] < SAT_MIN) begin
        c_im_d[i*CW +: CW] = SAT_MIN[CW-1:0];
        ovf_d = 1'b1;
      end else begin
        c_im_d[i*CW +: CW] = im_w[i][CW-1:0];
      end
    end
    ovf_d = ovf_d & valid_mode;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_re_q <= c_re_d;
      c_im_q <= c_im_d;
      ovf_q  <= ovf_d;
    end
  end

  assign c_re_o     = c_re_q;
  assign c_im_o     = c_im_q;
  assign overflow_o = ovf_q;

endmodule
`default_nettype wire
